// ===== hw/rtl/hll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_pkg
// Shared constants, controller states and control/status bundles of the
// HyperLogLog sketch.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int INDEX_BITS = 10;
  localparam int M          = 1 << INDEX_BITS;
  localparam int LOW_W      = 64 - INDEX_BITS;
  localparam int RANK_W     = 6;
  localparam int FRAC       = 56;
  localparam int SUM_W      = INDEX_BITS + FRAC + 1;
  localparam int ZERO_W     = INDEX_BITS + 1;
  localparam int SCALE_W    = 40;
  localparam int NUM_W      = SCALE_W + 48;
  localparam int OVER_STEPS = NUM_W - 64;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQ_STEPS   = FRAC;
  localparam int STEP_W     = (INDEX_BITS > 7) ? INDEX_BITS : 7;
  localparam int ADDR_W     = 4;

  localparam logic [RANK_W-1:0] EMPTY_RANK = RANK_W'(65 - INDEX_BITS);
  localparam logic [63:0] SMALL_LIM = 64'((5 * M) / 2);
  localparam logic [63:0] LARGE_TH  = 64'd614891469123651720;
  localparam logic [63:0] LN2_Q64   = 64'hB17217F7D1CF79AB;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd193337000;

  // register index decoded from paddr[ADDR_W-1:3] (64-bit registers)
  localparam logic REG_SCALE = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WRITE, ST_SWEEP, ST_DRAIN, ST_DIV_INIT,
    ST_DIV, ST_RANGE, ST_LOG, ST_SQ, ST_SQ_WAIT, ST_FIN, ST_FIN_WAIT, ST_RESULT
  } state_t;

  typedef struct packed {
    logic step_clr;
    logic step_inc;
    logic clr_wr;
    logic load_item;
    logic upd_rd;
    logic upd_wr;
    logic sweep_rd;
    logic div_init;
    logic div_step;
    logic range_sel;
    logic log_init;
    logic sq_start;
    logic sq_take;
    logic fin_start;
    logic fin_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mem_last;
    logic div_last;
    logic sq_last;
    logic need_log;
    logic mul_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/hll_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_mul
// 64x64 unsigned multiplier built from four 32x32 partial products, one per
// cycle, accumulated into a 128-bit result. done pulses when p is final.
// ----------------------------------------------------------------------------
module hll_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);
  import hll_pkg::*;

  logic        busy;
  logic [2:0]  cnt;
  logic [63:0] a_q, b_q;
  logic [63:0] prod;
  logic [31:0] a_part, b_part;
  logic [127:0] prod_sh;

  always_comb begin
    a_part = cnt[1] ? a_q[63:32] : a_q[31:0];
    b_part = cnt[0] ? b_q[63:32] : b_q[31:0];
    // cnt-1 selects the shift of the product registered last cycle
    unique case (cnt)
      3'd2, 3'd3: prod_sh = {32'd0, prod, 32'd0};
      3'd4:       prod_sh = {prod, 64'd0};
      default:    prod_sh = {64'd0, prod};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 3'd4);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      p   <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) prod <= a_part * b_part;
      if (cnt != 3'd0) p <= p + prod_sh;
    end
  end

endmodule

// ===== hw/rtl/hll_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_dp
// Datapath: rank store, register sweep, restoring divider, log2 by repeated
// squaring on the shared multiplier, and the output register.
// ----------------------------------------------------------------------------
module hll_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  hll_pkg::cmd_t                 cmd,
  output hll_pkg::stat_t                st,
  input  logic [63:0]                   hash_value,
  input  logic [hll_pkg::SCALE_W-1:0]   scale,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [63:0]                   out_estimate,
  output logic [15:0]                   out_bucket,
  output logic [hll_pkg::RANK_W-1:0]    out_rank
);
  import hll_pkg::*;

  logic [RANK_W-1:0]     mem [M];
  logic [RANK_W-1:0]     mem_rd;
  logic                  mem_we, mem_re;
  logic [INDEX_BITS-1:0] mem_waddr, mem_raddr;
  logic [RANK_W-1:0]     mem_wdata;

  logic [STEP_W-1:0]     step;
  logic [INDEX_BITS-1:0] bucket;
  logic [RANK_W-1:0]     rank, rank_next;
  logic [LOW_W-1:0]      low;
  logic                  sv;
  logic [SUM_W-1:0]      sum;
  logic [ZERO_W-1:0]     zeros;
  logic [NUM_W-1:0]      num;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W:0]        remsh;
  logic                  ge;
  logic [63:0]           q;
  logic                  over;
  logic [63:0]           est, x, y, res, l2;
  logic                  large_mode;
  logic                  is_small, is_large;
  logic [5:0]            k;
  logic                  mul_start, mul_done;
  logic [63:0]           mul_a, mul_b;
  logic [127:0]          mul_p;

  // rank of the incoming hash
  always_comb begin
    low       = hash_value[LOW_W-1:0];
    rank_next = EMPTY_RANK;
    for (int i = 0; i < LOW_W; i++) begin
      if (low[i]) rank_next = RANK_W'(LOW_W - i);
    end
  end

  always_comb begin
    mem_re    = cmd.upd_rd | cmd.sweep_rd;
    mem_raddr = cmd.upd_rd ? bucket : step[INDEX_BITS-1:0];
    mem_we    = cmd.clr_wr | (cmd.upd_wr && (rank > mem_rd));
    mem_waddr = cmd.clr_wr ? step[INDEX_BITS-1:0] : bucket;
    mem_wdata = cmd.clr_wr ? '0 : rank;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd <= mem[mem_raddr];
  end

  always_comb begin
    remsh    = {rem, num[NUM_W-1]};
    ge       = remsh >= {1'b0, sum};
    is_small = q <= SMALL_LIM;
    is_large = q > LARGE_TH;
    k        = '0;
    for (int i = 1; i < 64; i++) begin
      if (x[i]) k = 6'(i);
    end
    l2 = (large_mode ? (64'd64 << FRAC) : (64'(INDEX_BITS) << FRAC)) - res;
    mul_start = cmd.sq_start | cmd.fin_start;
    mul_a     = cmd.fin_start ? l2 : y;
    mul_b     = cmd.fin_start ? LN2_Q64 : y;
  end

  hll_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sv <= cmd.sweep_rd;
      if (cmd.step_clr)      step <= '0;
      else if (cmd.step_inc) step <= step + STEP_W'(1);
      if (cmd.out_load)      out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      bucket <= hash_value[63 -: INDEX_BITS];
      rank   <= rank_next;
      sum    <= '0;
      zeros  <= '0;
    end
    if (sv) begin
      if (mem_rd == '0) zeros <= zeros + ZERO_W'(1);
      if (mem_rd <= RANK_W'(FRAC)) sum <= sum + (SUM_W'(1) << (RANK_W'(FRAC) - mem_rd));
    end
    if (cmd.div_init) begin
      num  <= {scale, 48'd0};
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
    end
    if (cmd.div_step) begin
      // with an empty sum every step subtracts, so the quotient overflows
      rem <= ge ? SUM_W'(remsh - {1'b0, sum}) : SUM_W'(remsh);
      num <= num << 1;
      q   <= {q[62:0], ge};
      if (ge && (step < STEP_W'(OVER_STEPS))) over <= 1'b1;
    end
    if (cmd.range_sel) begin
      est        <= over ? '1 : q;
      x          <= is_small ? 64'(zeros) : (64'd0 - q);
      large_mode <= !is_small;
    end
    if (cmd.log_init) begin
      y   <= (k <= 6'd62) ? (x << (6'd62 - k)) : (x >> 1);
      res <= 64'(k) << FRAC;
    end
    if (cmd.sq_take) begin
      if (mul_p[125]) begin
        res <= res | (64'd1 << (6'(SQ_STEPS - 1) - step[5:0]));
        y   <= mul_p[126:63];
      end else begin
        y <= mul_p[125:62];
      end
    end
    if (cmd.fin_take) begin
      if (large_mode) est <= (mul_p[127:120] != '0) ? '1 : mul_p[119:56];
      else            est <= 64'(mul_p >> (120 - INDEX_BITS));
    end
    if (cmd.out_load) begin
      out_estimate <= est;
      out_bucket   <= 16'(bucket);
      out_rank     <= rank;
    end
  end

  always_comb begin
    st.mem_last = step[INDEX_BITS-1:0] == '1;
    st.div_last = step == STEP_W'(DIV_STEPS - 1);
    st.sq_last  = step == STEP_W'(SQ_STEPS - 1);
    st.need_log = !over && ((is_small && (zeros != '0)) || (!is_small && is_large));
    st.mul_done = mul_done;
    st.out_busy = out_valid && !out_ready;
  end

endmodule

// ===== hw/rtl/hll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hll_ctrl
// Controller: clears the store after reset, then sequences update, sweep,
// divide, optional log correction and result hand-off for each item.
// ----------------------------------------------------------------------------
module hll_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hll_pkg::stat_t st,
  output hll_pkg::cmd_t  cmd
);
  import hll_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.step_inc = 1'b1;
        if (st.mem_last) begin
          cmd.step_clr = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.upd_rd = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.upd_wr   = 1'b1;
        cmd.step_clr = 1'b1;
        state_next   = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        cmd.step_inc = 1'b1;
        if (st.mem_last) begin
          cmd.step_clr = 1'b1;
          state_next   = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.step_inc = 1'b1;
        if (st.div_last) begin
          cmd.step_clr = 1'b1;
          state_next   = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd.range_sel = 1'b1;
        state_next    = st.need_log ? ST_LOG : ST_RESULT;
      end
      ST_LOG: begin
        cmd.log_init = 1'b1;
        state_next   = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_start = 1'b1;
        state_next   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (st.mul_done) begin
          cmd.sq_take  = 1'b1;
          cmd.step_inc = 1'b1;
          if (st.sq_last) begin
            cmd.step_clr = 1'b1;
            state_next   = ST_FIN;
          end else begin
            state_next = ST_SQ;
          end
        end
      end
      ST_FIN: begin
        cmd.fin_start = 1'b1;
        state_next    = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (st.mul_done) begin
          cmd.fin_take = 1'b1;
          state_next   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== hw/rtl/hyperloglog_sketch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperloglog_sketch
// HyperLogLog cardinality estimator over 64-bit hashes, with an APB-style
// register port for the scale constant.
// ----------------------------------------------------------------------------
// channel   dir  transaction
// s_*       in   hash_value (64)
// m_*       out  estimate (64), bucket (16), rank (6)
// apb       in   estimate_scale at byte address 0 (64-bit data)
//
// An item's processing time is set by the sweep of the 1024-entry rank store (one
// read a cycle) plus the 88-step divider; a log correction adds 56 squarings
// on the shared 64x64 multiplier, a setup state and a final product.
// After reset all 1024 entries of the store are cleared before s_tready rises.
// One item is in flight; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module hyperloglog_sketch (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,   // [63:0] hash_value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [87:0]                  m_tdata,   // estimate, bucket, rank, pad
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hll_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import hll_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic               sel_scale;
  cmd_t               cmd;
  stat_t              st;
  logic [63:0]        out_estimate;
  logic [15:0]        out_bucket;
  logic [RANK_W-1:0]  out_rank;

  assign pready    = 1'b1;
  assign sel_scale = paddr[ADDR_W-1:3] == REG_SCALE;
  assign prdata    = sel_scale ? 64'(scale) : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && sel_scale) begin
      scale <= SCALE_W'(pwdata);
    end
  end

  hll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  hll_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .hash_value   (s_tdata),
    .scale        (scale),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_estimate (out_estimate),
    .out_bucket   (out_bucket),
    .out_rank     (out_rank)
  );

  assign m_tdata = {2'b00, out_rank, out_bucket, out_estimate};

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_rank != '0) && (out_rank <= EMPTY_RANK))
    else $error("result rank out of range");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_bucket < 16'(M)))
    else $error("result bucket out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten before it was taken");

endmodule
